FILE: design/tpbr_pkg.sv
// types, constants and cell classification shared by the pattern-to-rows block
package tpbr_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMPO    = 2'd2;

	localparam logic [5:0] CHANNELS_RESET = 6'd2;
	localparam logic [8:0] ROWS_RESET     = 9'd64;
	localparam logic [4:0] TEMPO_RESET    = 5'd6;

	localparam int FLAG_BIT  = 7;
	localparam int FLD_NOTE  = 0;
	localparam int FLD_INS   = 1;
	localparam int FLD_EFF   = 3;
	localparam int FLD_PARAM = 4;
	localparam logic [4:0] MASK_RAW = 5'b11110;

	localparam logic [7:0] EFF_TEMPO   = 8'h0f;
	localparam logic [7:0] TEMPO_LIMIT = 8'h20;
	localparam logic [7:0] INS_MELODIC = 8'd1;
	localparam logic [7:0] INS_DRUM    = 8'd2;
	localparam logic [7:0] NOTE_LOW    = 8'd24;
	localparam logic [7:0] TONE_SPAN   = 8'd47;
	localparam logic [7:0] NOTE_OFF    = 8'd97;

	localparam int QUEUE_DEPTH = 4;
	localparam int QA_W        = 2;

	localparam int TDATA_W = 24;

	typedef struct packed {
		logic       set_tempo;
		logic [4:0] tempo;
		logic       tone_load;
		logic       tone_clear;
		logic [5:0] tone;
		logic       warn;
		logic [2:0] drum;
	} cell_t;

	function automatic logic [2:0] drum_code(logic [7:0] note);
		logic [2:0] d;
		case (note)
			8'd49: d = 3'd1;
			8'd51: d = 3'd2;
			8'd53: d = 3'd3;
			8'd54: d = 3'd4;
			8'd56: d = 3'd5;
			8'd58: d = 3'd6;
			8'd60: d = 3'd7;
			default: d = 3'd0;
		endcase
		return d;
	endfunction

	function automatic cell_t classify(logic [7:0] note, logic [7:0] ins, logic [7:0] eff,
			logic [7:0] param);
		cell_t c;
		logic  melodic;
		logic  in_rng;
		c = '0;
		c.set_tempo = (eff == EFF_TEMPO) && (param < TEMPO_LIMIT);
		c.tempo = param[4:0];
		melodic = (ins == INS_MELODIC) && (note != 8'd0) && (note < NOTE_OFF);
		in_rng = (note >= NOTE_LOW) && (note < (NOTE_LOW + TONE_SPAN));
		c.tone_load = melodic && in_rng;
		c.tone = 6'(note - (NOTE_LOW - 8'd1));
		c.warn = melodic && !in_rng;
		c.tone_clear = (note == NOTE_OFF);
		c.drum = (ins == INS_DRUM) ? drum_code(note) : 3'd0;
		return c;
	endfunction

endpackage

FILE: design/tpbr_front.sv
// byte parser: assembles packed cells and classifies each finished cell
module tpbr_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     byte_in,
	output logic           push,
	output tpbr_pkg::cell_t cell_cls
);
	import tpbr_pkg::*;

	logic       phase_q;
	logic [4:0] mask_q;
	logic [7:0] note_q;
	logic [7:0] ins_q;
	logic [7:0] eff_q;

	logic [4:0] lowbit;
	logic [4:0] mask_n;
	logic [7:0] note_n;
	logic [7:0] ins_n;
	logic [7:0] eff_n;
	logic [7:0] param_n;
	logic       cell_done;

	always_comb begin
		lowbit  = mask_q & (~mask_q + 5'd1);
		mask_n  = mask_q & ~lowbit;
		note_n  = lowbit[FLD_NOTE] ? byte_in : note_q;
		ins_n   = lowbit[FLD_INS] ? byte_in : ins_q;
		eff_n   = lowbit[FLD_EFF] ? byte_in : eff_q;
		param_n = lowbit[FLD_PARAM] ? byte_in : 8'd0;
		if (!phase_q) begin
			cell_done = byte_in[FLAG_BIT] && (byte_in[4:0] == 5'd0);
			cell_cls = classify(8'd0, 8'd0, 8'd0, 8'd0);
		end else begin
			cell_done = lowbit[FLD_PARAM] || (mask_n == 5'd0);
			cell_cls = classify(note_n, ins_n, eff_n, param_n);
		end
	end

	assign push = accept && cell_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			mask_q  <= 5'd0;
			note_q  <= 8'd0;
			ins_q   <= 8'd0;
			eff_q   <= 8'd0;
		end else if (accept) begin
			if (!phase_q) begin
				ins_q <= 8'd0;
				eff_q <= 8'd0;
				if (byte_in[FLAG_BIT]) begin
					note_q  <= 8'd0;
					mask_q  <= byte_in[4:0];
					phase_q <= (byte_in[4:0] != 5'd0);
				end else begin
					note_q  <= byte_in;
					mask_q  <= MASK_RAW;
					phase_q <= 1'b1;
				end
			end else begin
				note_q  <= note_n;
				ins_q   <= ins_n;
				eff_q   <= eff_n;
				mask_q  <= cell_done ? 5'd0 : mask_n;
				phase_q <= !cell_done;
			end
		end
	end

endmodule

FILE: design/tpbr_queue.sv
// short cell queue between parser and row builder
module tpbr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tpbr_pkg::cell_t din,
	input  logic            pop,
	output tpbr_pkg::cell_t dout,
	output logic            valid,
	output logic            full
);
	import tpbr_pkg::*;

	cell_t           entry_q [QUEUE_DEPTH];
	logic [QA_W-1:0] wr_ptr_q;
	logic [QA_W-1:0] rd_ptr_q;
	logic [QA_W:0]   count_q;

	assign valid = (count_q != '0);
	assign full  = (count_q == (QA_W+1)'(QUEUE_DEPTH));
	assign dout  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QA_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QA_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QA_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QA_W+1)'(1);
			end
		end
	end

endmodule

FILE: design/tpbr_back.sv
// row builder: applies cells to row state, holds settings and the output register
module tpbr_back #(
	parameter int MAX_CHANNELS = 32,
	parameter int MAX_ROWS     = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tpbr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tpbr_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               q_valid,
	input  tpbr_pkg::cell_t                    cell_cls,
	output logic                               pop,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [tpbr_pkg::TDATA_W-1:0]       m_tdata,
	output logic                               m_tlast
);
	import tpbr_pkg::*;

	localparam int CH_W  = $clog2(MAX_CHANNELS);
	localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int RCW   = $clog2(MAX_ROWS + 1);

	logic [5:0]      channels_q;
	logic [8:0]      rows_q;
	logic [4:0]      tempo_q;
	logic [CH_W-1:0] ch_q;
	logic [RW-1:0]   row_q;
	logic [5:0]      held_a_q;
	logic [5:0]      held_b_q;
	logic [2:0]      drum_q;
	logic            warn_q;
	logic            out_valid_q;
	logic [7:0]      tone_a_q;
	logic [7:0]      tone_b_q;
	logic [5:0]      speed_q;
	logic            warn_out_q;
	logic            last_q;

	logic [CNT_W-1:0] eff_ch;
	logic [RCW-1:0]   eff_rows;
	logic [4:0]       tempo_n;
	logic [5:0]       held_a_n;
	logic [5:0]       held_b_n;
	logic [2:0]       drum_n;
	logic             warn_n;
	logic             row_done;
	logic             last_n;

	always_comb begin
		if ({1'b0, channels_q} < 7'd2) begin
			eff_ch = CNT_W'(2);
		end else if ({1'b0, channels_q} > 7'(MAX_CHANNELS)) begin
			eff_ch = CNT_W'(MAX_CHANNELS);
		end else begin
			eff_ch = CNT_W'(channels_q);
		end
		if (rows_q == 9'd0) begin
			eff_rows = RCW'(1);
		end else if (rows_q > 9'(MAX_ROWS)) begin
			eff_rows = RCW'(MAX_ROWS);
		end else begin
			eff_rows = RCW'(rows_q);
		end

		tempo_n = cell_cls.set_tempo ? cell_cls.tempo : tempo_q;
		held_a_n = held_a_q;
		held_b_n = held_b_q;
		if (ch_q == CH_W'(0)) begin
			if (cell_cls.tone_load) begin
				held_a_n = cell_cls.tone;
			end else if (cell_cls.tone_clear) begin
				held_a_n = 6'd0;
			end
		end
		if (ch_q == CH_W'(1)) begin
			if (cell_cls.tone_load) begin
				held_b_n = cell_cls.tone;
			end else if (cell_cls.tone_clear) begin
				held_b_n = 6'd0;
			end
		end
		warn_n = warn_q || (cell_cls.warn && ((ch_q == CH_W'(0)) || (ch_q == CH_W'(1))));
		drum_n = (cell_cls.drum != 3'd0) ? cell_cls.drum : drum_q;
		row_done = (CNT_W'(ch_q) + CNT_W'(1)) >= eff_ch;
		last_n = (RCW'(row_q) + RCW'(1)) >= eff_rows;
	end

	assign pop      = q_valid && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {1'b0, warn_out_q, speed_q, tone_b_q, tone_a_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channels_q  <= CHANNELS_RESET;
			rows_q      <= ROWS_RESET;
			tempo_q     <= TEMPO_RESET;
			ch_q        <= '0;
			row_q       <= '0;
			held_a_q    <= 6'd0;
			held_b_q    <= 6'd0;
			drum_q      <= 3'd0;
			warn_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && row_done) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				tempo_q <= tempo_n;
				if (row_done) begin
					ch_q        <= '0;
					drum_q      <= 3'd0;
					warn_q      <= 1'b0;
					if (last_n) begin
						row_q    <= '0;
						held_a_q <= 6'd0;
						held_b_q <= 6'd0;
					end else begin
						row_q    <= RW'(RCW'(row_q) + RCW'(1));
						held_a_q <= held_a_n;
						held_b_q <= held_b_n;
					end
				end else begin
					ch_q     <= ch_q + CH_W'(1);
					held_a_q <= held_a_n;
					held_b_q <= held_b_n;
					drum_q   <= drum_n;
					warn_q   <= warn_n;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_CHANNELS: channels_q <= cfg_data[5:0];
					CFG_ROWS:     rows_q <= cfg_data;
					CFG_TEMPO:    tempo_q <= cfg_data[4:0];
					default:      ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && row_done) begin
			tone_a_q   <= {drum_n[2], 1'b0, held_a_n};
			tone_b_q   <= {drum_n[1:0], held_b_n};
			speed_q    <= last_n ? (6'(tempo_n) + 6'd1) : 6'd0;
			warn_out_q <= warn_n;
			last_q     <= last_n;
		end
	end

endmodule

FILE: design/tracker_pattern_to_beeper_rows_core.sv
// top level of the packed pattern to beeper row converter
//
// input stream: one packed pattern byte per beat on s_tdata; a new byte can
// be taken every cycle while the queue is not full, so sustained throughput is one byte per cycle.
// the parser assembles cells and drops each finished cell into a four-entry
// queue; the row builder takes one cell per cycle while its output register is
// free or being taken and, after the last cell of a row, loads the output register.
// output stream: one beat per row on m_tdata, m_tlast marks the pattern's
// last row. a row's final cell passes through the queue before the row builder
// takes it and loads the output register, from which the row is offered.
// settings are written through cfg_we/cfg_index/cfg_data, by the user only
// while no row is in flight (not enforced); a tempo write loads the running tempo at once.
// reset: parser, row position, held tones and queue clear; settings return
// to two channels, 64 rows, tempo 6.
// when m_tready is low the row stays in the output register, the builder
// stops, the queue fills and then s_tready drops until space frees up.
module tracker_pattern_to_beeper_rows_core #(
	parameter int MAX_CHANNELS = 32,
	parameter int MAX_ROWS     = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // pattern_byte
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// tone_a_byte, tone_b_byte, pattern_speed, range_warning, zero pad
	output logic [tpbr_pkg::TDATA_W-1:0]    m_tdata,
	output logic                            m_tlast,  // last_row
	input  logic                            cfg_we,
	input  logic [tpbr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpbr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tpbr_pkg::*;

	logic  accept;
	logic  push;
	logic  pop;
	logic  q_valid;
	logic  q_full;
	cell_t push_cell;
	cell_t pop_cell;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	tpbr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.byte_in  (s_tdata),
		.push     (push),
		.cell_cls (push_cell)
	);

	tpbr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_cell),
		.pop    (pop),
		.dout   (pop_cell),
		.valid  (q_valid),
		.full   (q_full)
	);

	tpbr_back #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.MAX_ROWS     (MAX_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.cell_cls  (pop_cell),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

FILE: design/tpbr_checker.sv
// port-level checks for the pattern to beeper row converter, bound to the top level
module tpbr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [tpbr_pkg::TDATA_W-1:0] m_tdata,
	input logic                         m_tlast
);
	import tpbr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	a_speed_mid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> (m_tdata[21:16] == 6'd0))
		else $error("speed on a row that is not last");

	a_speed_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata[21:16] != 6'd0))
		else $error("zero speed on last row");

	a_unused_bits: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6] == 1'b0) && (m_tdata[23] == 1'b0))
		else $error("unused output bits set");

endmodule

bind tracker_pattern_to_beeper_rows_core tpbr_checker u_tpbr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

FILE: sim/tb.sv
// testbench for the packed pattern to beeper row converter: predicted rows checked beat by beat
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tpbr_pkg::*;

	localparam int MAX_CH = 32;
	localparam int MAX_RW = 256;
	localparam int DRAIN_CYCLES = 12;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct {
		logic [7:0] tone_a;
		logic [7:0] tone_b;
		logic       last;
		logic [5:0] speed;
		logic       warn;
	} beeper_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = 8'd0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [TDATA_W-1:0]    m_tdata;
	logic                  m_tlast;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_CHANNELS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	tracker_pattern_to_beeper_rows_core #(
		.MAX_CHANNELS(MAX_CH),
		.MAX_ROWS    (MAX_RW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// row predictor state
	logic [5:0]  chan_cfg = CHANNELS_RESET;
	logic [8:0]  rows_cfg = ROWS_RESET;
	logic [4:0]  tempo_now = TEMPO_RESET;
	bit          in_cell = 1'b0;
	logic [4:0]  fields_left = '0;
	logic [7:0]  cell_note = '0;
	logic [7:0]  cell_ins = '0;
	logic [7:0]  cell_eff = '0;
	int          chan_pos = 0;
	int          row_pos = 0;
	logic [5:0]  tone_a = '0;
	logic [5:0]  tone_b = '0;
	logic [2:0]  drum_now = '0;
	logic        warn_now = 1'b0;
	beeper_row_t pending_rows[$];

	int errors = 0;
	int sent_bytes = 0;
	int quiet_cycles = 0;
	bit send_idle_on = 1'b1;
	bit recv_idle_on = 1'b1;
	bit hold_req = 1'b0;
	int hold_len = 0;
	int hold_left = 0;
	int stall_left = 0;

	function automatic int eff_channels();
		if (chan_cfg < 2) return 2;
		if (chan_cfg > MAX_CH) return MAX_CH;
		return chan_cfg;
	endfunction

	function automatic int eff_rows();
		if (rows_cfg < 1) return 1;
		if (rows_cfg > MAX_RW) return MAX_RW;
		return rows_cfg;
	endfunction

	function automatic logic [2:0] drum_of(logic [7:0] note);
		case (note)
			8'd49: return 3'd1;
			8'd51: return 3'd2;
			8'd53: return 3'd3;
			8'd54: return 3'd4;
			8'd56: return 3'd5;
			8'd58: return 3'd6;
			8'd60: return 3'd7;
			default: return 3'd0;
		endcase
	endfunction

	task automatic close_cell(input logic [7:0] param);
		beeper_row_t row;
		logic [2:0]  d;
		bit          at_end;
		if (cell_eff == EFF_TEMPO && param < TEMPO_LIMIT)
			tempo_now = param[4:0];
		if (chan_pos < 2) begin
			if (cell_note != 8'd0 && cell_note < NOTE_OFF && cell_ins == INS_MELODIC) begin
				if (cell_note >= NOTE_LOW && cell_note < NOTE_LOW + TONE_SPAN) begin
					if (chan_pos == 0)
						tone_a = 6'(cell_note - NOTE_LOW + 8'd1);
					else
						tone_b = 6'(cell_note - NOTE_LOW + 8'd1);
				end else begin
					warn_now = 1'b1;
				end
			end
			if (cell_note == NOTE_OFF) begin
				if (chan_pos == 0)
					tone_a = '0;
				else
					tone_b = '0;
			end
		end
		if (cell_ins == INS_DRUM) begin
			d = drum_of(cell_note);
			if (d != 3'd0)
				drum_now = d;
		end
		in_cell = 1'b0;
		fields_left = '0;
		cell_note = '0;
		cell_ins = '0;
		cell_eff = '0;
		chan_pos++;
		if (chan_pos >= eff_channels()) begin
			at_end = (row_pos + 1) >= eff_rows();
			row.tone_a = {drum_now[2], 1'b0, tone_a};
			row.tone_b = {drum_now[1:0], tone_b};
			row.last = at_end;
			row.speed = at_end ? 6'(tempo_now + 6'd1) : 6'd0;
			row.warn = warn_now;
			pending_rows.push_back(row);
			chan_pos = 0;
			drum_now = '0;
			warn_now = 1'b0;
			if (at_end) begin
				row_pos = 0;
				tone_a = '0;
				tone_b = '0;
			end else begin
				row_pos++;
			end
		end
	endtask

	task automatic absorb_byte(input logic [7:0] b);
		int fld;
		if (!in_cell) begin
			cell_note = '0;
			cell_ins = '0;
			cell_eff = '0;
			if (b[FLAG_BIT]) begin
				fields_left = b[4:0];
				if (fields_left == 5'd0) begin
					close_cell(8'd0);
					return;
				end
			end else begin
				cell_note = b;
				fields_left = MASK_RAW;
			end
			in_cell = 1'b1;
			return;
		end
		fld = 0;
		while (fld < 5 && !fields_left[fld])
			fld++;
		if (fld >= 5) begin
			close_cell(8'd0);
			return;
		end
		fields_left[fld] = 1'b0;
		case (fld)
			FLD_NOTE: cell_note = b;
			FLD_INS: cell_ins = b;
			FLD_EFF: cell_eff = b;
			FLD_PARAM: begin
				close_cell(b);
				return;
			end
			default: ;
		endcase
		if (fields_left == 5'd0)
			close_cell(8'd0);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_note();
		logic [7:0] drums[7] = '{8'd49, 8'd51, 8'd53, 8'd54, 8'd56, 8'd58, 8'd60};
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) return 8'($urandom_range(24, 70));
		if (r == 4) return $urandom_range(0, 1) ? 8'($urandom_range(1, 23))
			: 8'($urandom_range(71, 96));
		if (r == 5) return NOTE_OFF;
		if (r < 8) return drums[$urandom_range(0, 6)];
		if (r == 8) return 8'd0;
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] pick_ins();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) return INS_MELODIC;
		if (r < 8) return INS_DRUM;
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] pick_eff();
		if ($urandom_range(0, 9) < 4) return EFF_TEMPO;
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] pick_param();
		if ($urandom_range(0, 9) < 6) return 8'($urandom_range(0, 31));
		return 8'($urandom);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = send_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		sent_bytes++;
		absorb_byte(b);
	endtask

	task automatic send_random_cell();
		logic [7:0] f[5];
		logic [4:0] mask;
		int         kind;
		f[0] = pick_note();
		f[1] = pick_ins();
		f[2] = 8'($urandom);
		f[3] = pick_eff();
		f[4] = pick_param();
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			mask = 5'($urandom);
			send_byte({1'b1, 2'($urandom), mask});
			for (int i = 0; i < 5; i++)
				if (mask[i])
					send_byte(f[i]);
		end else if (kind < 9) begin
			send_byte({1'b0, f[0][6:0]});
			for (int i = 1; i < 5; i++)
				send_byte(f[i]);
		end else begin
			send_byte(8'($urandom));
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_CHANNELS: chan_cfg = val[5:0];
			CFG_ROWS: rows_cfg = val;
			CFG_TEMPO: tempo_now = val[4:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// raw and flagged cells, range edges, drums, tempo and empty cells
	task automatic test_directed_cells();
		logic [7:0] seq[26] = '{
			8'd24, 8'd1, 8'h40, 8'h0f, 8'h1f,
			8'h83, 8'd70, 8'd1,
			8'he3, 8'd23, 8'd1,
			8'h80,
			8'h8a, 8'd2, 8'h0f,
			8'h83, 8'd49, 8'd2,
			8'h83, 8'd60, 8'd2,
			8'h9b, 8'd58, 8'd2, 8'h0f, 8'h20
		};
		program_reg(CFG_ROWS, 9'd2);
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	// shorter pattern and row length written while a pattern is under way
	task automatic test_register_change();
		logic [7:0] full_cell[6] = '{8'hff, 8'd96, 8'd1, 8'hff, 8'h0f, 8'h00};
		program_reg(CFG_CHANNELS, 9'd2);
		program_reg(CFG_ROWS, 9'd8);
		program_reg(CFG_TEMPO, 9'd5);
		repeat (4) send_byte(8'h80);
		program_reg(CFG_ROWS, 9'd1);
		foreach (full_cell[i])
			send_byte(full_cell[i]);
		send_byte(8'h80);
		program_reg(CFG_CHANNELS, 9'd5);
		repeat (3) send_byte(8'h80);
		program_reg(CFG_CHANNELS, 9'd0);
		program_reg(CFG_TEMPO, 9'd31);
		send_byte(8'h80);
	endtask

	// receiver holds off while the sender keeps offering beats
	task automatic test_backpressure();
		program_reg(CFG_CHANNELS, 9'd2);
		program_reg(CFG_ROWS, 9'd3);
		send_idle_on = 1'b0;
		hold_len = 300;
		hold_req = 1'b1;
		repeat (60) send_byte(8'h80);
		send_idle_on = 1'b1;
	endtask

	// one whole pattern at the largest row count, mostly empty cells
	task automatic test_full_pattern();
		program_reg(CFG_CHANNELS, 9'd1);
		program_reg(CFG_ROWS, 9'h1ff);
		program_reg(CFG_TEMPO, 9'($urandom_range(0, 31)));
		for (int c = 0; c < 2 * MAX_RW + 6; c++) begin
			if ($urandom_range(0, 99) < 88)
				send_byte({1'b1, 2'($urandom), 5'd0});
			else
				send_random_cell();
		end
	endtask

	task automatic test_random_settings();
		int ch_tab[7] = '{3, 0, 32, 2, 63, 4, 2};
		int rw_tab[7] = '{4, 0, 2, 1, 511, 7, 3};
		int stop_at;
		int tempo;
		for (int p = 0; p < 7; p++) begin
			tempo = (p == 1) ? 31 : (p == 2) ? 0 : $urandom_range(0, 31);
			program_reg(CFG_CHANNELS, {3'($urandom), 6'(ch_tab[p])});
			program_reg(CFG_ROWS, 9'(rw_tab[p]));
			program_reg(CFG_TEMPO, {4'($urandom), 5'(tempo)});
			send_idle_on = (p % 3 != 2);
			recv_idle_on = (p % 3 != 2);
			stop_at = sent_bytes + 90;
			while (sent_bytes < stop_at)
				send_random_cell();
		end
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = hold_len;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			if (recv_idle_on)
				stall_left = pick_gap();
		end
	end

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		beeper_row_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_rows.size() == 0) begin
				$display("%0t: row beat expected none actual tdata %h tlast %b",
					$time, m_tdata, m_tlast);
				errors++;
			end else begin
				want = pending_rows.pop_front();
				check_field("tone_a_byte", want.tone_a, m_tdata[7:0]);
				check_field("tone_b_byte", want.tone_b, m_tdata[15:8]);
				check_field("pattern_speed", want.speed, m_tdata[21:16]);
				check_field("range_warning", want.warn, m_tdata[22]);
				check_field("last_row", want.last, m_tlast);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		test_directed_cells();
		test_register_change();
		test_backpressure();
		test_full_pattern();
		test_random_settings();
		wait_drained();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
